FILE: rtl/lrec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrec_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int RADIUS_BITS    = 10;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_STEP = 1'b1
	} action_t;

	// Per-beat flags that ride along the pipeline next to the pixel.
	typedef struct packed {
		logic last;
		logic no_line;
	} beat_flags_t;

endpackage

`default_nettype wire

FILE: rtl/line_raster_with_endpoint_clearance.sv
`timescale 1ns / 1ps
`default_nettype none
// Line rasterizer with endpoint clearance, all octants.
// Input channel (in_valid / in_stall): one beat is either a load (action low),
// carrying both endpoints, or a step (action high), advancing one pixel.
// Every input beat yields exactly one output beat on the output channel
// (out_valid / out_stall): the pixel, whether it is visible (outside or on the
// clearance circle of both endpoints), whether it is the final endpoint, and
// no_line when a step arrived without a line in progress.
// Configuration channel (cfg_valid / cfg_ready, always ready): clear_radius;
// write it only while no beat is in flight.
// Three register stages: line state update, then the four squared gaps,
// then the adds and compares. out_valid rises once the beat has been
// registered in stage 1, then in stage 2, then in stage 3.
// Throughput is one beat per cycle while out_stall is low; the Bresenham
// error update and the squares each sit in their own register stage.
// Reset clears the line state (no line active), the radius and all stage
// valids. When the receiver stalls, the output beat holds and the stages
// behind it fill; in_stall rises only once all three stages hold beats while
// out_stall is high, and it follows out_stall combinationally.
module line_raster_with_endpoint_clearance
	import lrec_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [RADIUS_BITS-1:0] clear_radius,
	// input channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   action,
	input  wire logic [COORD_BITS-1:0]  x_start,
	input  wire logic [COORD_BITS-1:0]  y_start,
	input  wire logic [COORD_BITS-1:0]  x_end,
	input  wire logic [COORD_BITS-1:0]  y_end,
	// output channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [COORD_BITS-1:0]       pixel_x,
	output logic [COORD_BITS-1:0]       pixel_y,
	output logic                        visible,
	output logic                        last,
	output logic                        no_line
);

	localparam int EW    = COORD_BITS + 3;      // error term, two's complement
	localparam int SQ_W  = 2 * COORD_BITS;      // one squared coordinate gap
	localparam int R2_W  = 2 * RADIUS_BITS;
	localparam int CMP_W = (SQ_W + 1 > R2_W) ? SQ_W + 1 : R2_W;

	localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		abs_diff = (a >= b) ? a - b : b - a;
	endfunction

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [RADIUS_BITS-1:0] radius_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= clear_radius;
		end
	end

	// ---------------------------------------------------------------
	// Handshake: each stage moves when it is empty or the next one moves
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic accept;

	assign rdy_s3   = !valid_s3 || !out_stall;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign accept   = in_valid && rdy_s1;

	// ---------------------------------------------------------------
	// Line state
	// ---------------------------------------------------------------
	logic [COORD_BITS-1:0] pos_x_q, pos_y_q, from_x_q, from_y_q, to_x_q, to_y_q;
	logic [EW-1:0]         err_q;
	logic [COORD_BITS-1:0] dmaj_q, dmin_q, steps_q;
	logic                  x_major_q, x_down_q, y_down_q, active_q;

	logic [COORD_BITS-1:0] pos_x_d, pos_y_d, from_x_d, from_y_d, to_x_d, to_y_d;
	logic [EW-1:0]         err_d;
	logic [COORD_BITS-1:0] dmaj_d, dmin_d, steps_d;
	logic                  x_major_d, x_down_d, y_down_d, active_d;
	beat_flags_t           flags_d;

	logic [COORD_BITS-1:0] span_x, span_y, ld_major, ld_minor;
	logic                  ld_x_down, ld_y_down, ld_x_major;
	logic [COORD_BITS-1:0] steps_dec;
	logic                  err_nonneg;

	always_comb begin
		// load setup
		ld_x_down  = x_end < x_start;
		ld_y_down  = y_end < y_start;
		span_x     = ld_x_down ? x_start - x_end : x_end - x_start;
		span_y     = ld_y_down ? y_start - y_end : y_end - y_start;
		ld_x_major = span_x > span_y;   // ties go to y
		ld_major   = ld_x_major ? span_x : span_y;
		ld_minor   = ld_x_major ? span_y : span_x;

		steps_dec  = steps_q - ONE;
		err_nonneg = !err_q[EW-1];

		// hold by default
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		from_x_d  = from_x_q;
		from_y_d  = from_y_q;
		to_x_d    = to_x_q;
		to_y_d    = to_y_q;
		err_d     = err_q;
		dmaj_d    = dmaj_q;
		dmin_d    = dmin_q;
		steps_d   = steps_q;
		x_major_d = x_major_q;
		x_down_d  = x_down_q;
		y_down_d  = y_down_q;
		active_d  = active_q;
		flags_d   = '{last: 1'b0, no_line: 1'b0};

		case (action_t'(action))
			ACT_LOAD: begin
				from_x_d  = x_start;
				from_y_d  = y_start;
				to_x_d    = x_end;
				to_y_d    = y_end;
				pos_x_d   = x_start;
				pos_y_d   = y_start;
				x_down_d  = ld_x_down;
				y_down_d  = ld_y_down;
				x_major_d = ld_x_major;
				dmaj_d    = ld_major;
				dmin_d    = ld_minor;
				err_d     = {2'b00, ld_minor, 1'b0} - {3'b000, ld_major};
				steps_d   = ld_major;
				active_d  = (ld_major != '0);
				flags_d.last = (ld_major == '0);
			end
			ACT_STEP: begin
				if (!active_q) begin
					flags_d.no_line = 1'b1;
				end else begin
					// minor-axis move when the error term is not negative
					if (err_nonneg) begin
						if (x_major_q) begin
							pos_y_d = y_down_q ? pos_y_q - ONE : pos_y_q + ONE;
						end else begin
							pos_x_d = x_down_q ? pos_x_q - ONE : pos_x_q + ONE;
						end
						err_d = err_q + {2'b00, dmin_q, 1'b0} - {2'b00, dmaj_q, 1'b0};
					end else begin
						err_d = err_q + {2'b00, dmin_q, 1'b0};
					end
					// major-axis move every step
					if (x_major_q) begin
						pos_x_d = x_down_q ? pos_x_q - ONE : pos_x_q + ONE;
					end else begin
						pos_y_d = y_down_q ? pos_y_q - ONE : pos_y_q + ONE;
					end
					steps_d      = steps_dec;
					active_d     = (steps_dec != '0);
					flags_d.last = (steps_dec == '0);
				end
			end
			default: begin
				flags_d.no_line = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			from_x_q  <= '0;
			from_y_q  <= '0;
			to_x_q    <= '0;
			to_y_q    <= '0;
			err_q     <= '0;
			dmaj_q    <= '0;
			dmin_q    <= '0;
			steps_q   <= '0;
			x_major_q <= 1'b0;
			x_down_q  <= 1'b0;
			y_down_q  <= 1'b0;
			active_q  <= 1'b0;
		end else if (accept) begin
			pos_x_q   <= pos_x_d;
			pos_y_q   <= pos_y_d;
			from_x_q  <= from_x_d;
			from_y_q  <= from_y_d;
			to_x_q    <= to_x_d;
			to_y_q    <= to_y_d;
			err_q     <= err_d;
			dmaj_q    <= dmaj_d;
			dmin_q    <= dmin_d;
			steps_q   <= steps_d;
			x_major_q <= x_major_d;
			x_down_q  <= x_down_d;
			y_down_q  <= y_down_d;
			active_q  <= active_d;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: the reported pixel and both endpoints
	// ---------------------------------------------------------------
	logic [COORD_BITS-1:0] px_s1, py_s1, fx_s1, fy_s1, tx_s1, ty_s1;
	beat_flags_t           flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1    <= pos_x_d;
			py_s1    <= pos_y_d;
			fx_s1    <= from_x_d;
			fy_s1    <= from_y_d;
			tx_s1    <= to_x_d;
			ty_s1    <= to_y_d;
			flags_s1 <= flags_d;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: squared gaps to each endpoint, and the radius squared
	// ---------------------------------------------------------------
	logic [COORD_BITS-1:0] gx1, gy1, gx2, gy2;
	logic [SQ_W-1:0]       sx1_s2, sy1_s2, sx2_s2, sy2_s2;
	logic [R2_W-1:0]       r2_s2;
	logic [COORD_BITS-1:0] px_s2, py_s2;
	beat_flags_t           flags_s2;

	assign gx1 = abs_diff(px_s1, fx_s1);
	assign gy1 = abs_diff(py_s1, fy_s1);
	assign gx2 = abs_diff(px_s1, tx_s1);
	assign gy2 = abs_diff(py_s1, ty_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			sx1_s2   <= SQ_W'(gx1) * SQ_W'(gx1);
			sy1_s2   <= SQ_W'(gy1) * SQ_W'(gy1);
			sx2_s2   <= SQ_W'(gx2) * SQ_W'(gx2);
			sy2_s2   <= SQ_W'(gy2) * SQ_W'(gy2);
			r2_s2    <= R2_W'(radius_q) * R2_W'(radius_q);
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			flags_s2 <= flags_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: sum, compare and drive the output beat
	// ---------------------------------------------------------------
	logic [CMP_W-1:0] dist1, dist2, r2_ext;
	logic             vis_comb;

	assign dist1    = CMP_W'(sx1_s2) + CMP_W'(sy1_s2);
	assign dist2    = CMP_W'(sx2_s2) + CMP_W'(sy2_s2);
	assign r2_ext   = CMP_W'(r2_s2);
	assign vis_comb = (dist1 >= r2_ext) && (dist2 >= r2_ext);

	logic [COORD_BITS-1:0] px_s3, py_s3;
	logic                  vis_s3, last_s3, noline_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			// a step without a line reports zeros apart from no_line
			px_s3     <= flags_s2.no_line ? '0 : px_s2;
			py_s3     <= flags_s2.no_line ? '0 : py_s2;
			vis_s3    <= vis_comb && !flags_s2.no_line;
			last_s3   <= flags_s2.last;
			noline_s3 <= flags_s2.no_line;
		end
	end

	assign out_valid = valid_s3;
	assign pixel_x   = px_s3;
	assign pixel_y   = py_s3;
	assign visible   = vis_s3;
	assign last      = last_s3;
	assign no_line   = noline_s3;

endmodule

`default_nettype wire
